@@ sv/bmhq_pkg.sv @@
// Shared types and constants for the binary max-heap priority queue.
package bmhq_pkg;

  localparam int ValueW = 32;
  localparam int CountOutW = 5;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Largest signed value; fed in ahead of the first cell so that it never shifts.
  localparam logic signed [ValueW-1:0] VAL_MAX = {1'b0, {(ValueW-1){1'b1}}};

  // Command broadcast to every cell of the chain at once.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } bmhq_cmd_t;

endpackage

@@ sv/binary_max_heap_queue_core.sv @@
// Top level of the bounded max-priority queue built from a chain of sorting cells.
//
// The queue holds up to CAPACITY signed 32-bit values. Each input transaction
// is either an insert (tuser = 0, value in tdata) or a remove-maximum
// (tuser = 1, tdata ignored), and yields exactly one output transaction that
// reports whether the request was done, the largest value taken out (zero for
// an insert or a refused remove) and the number of entries held afterwards,
// reported modulo 32. Inserts into a full queue and removes from an empty one
// are refused and leave the contents untouched. Entries sit in a row of
// CAPACITY identical cells kept in descending order, so the maximum is always
// in the first cell: an insert makes every cell compare the new value with its
// own entry and its upper neighbor's in the same cycle and shift down by one
// where needed, and a remove shifts every entry up by one. Either operation
// therefore updates all cells together, and a new request is taken in every
// cycle in which the output register is empty or its result is being taken;
// the result appears on the output in the cycle after the request is accepted.
// Latency does not depend on CAPACITY, which sets only the length of the cell
// row and the fan-out of the command broadcast.
module binary_max_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] count_after, rest zero
  output logic        m_tuser    // [0] accepted
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]          count;
  logic [CntW-1:0]          count_next;
  logic                     s_fire;
  logic                     full;
  logic                     empty;
  logic                     ok;
  bmhq_cmd_t                cmd;
  logic signed [ValueW-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      occ;
  logic [CntW+CountOutW-1:0] count_wide;

  // The output register parts the two sides: a new request is taken whenever
  // the pending result is absent or leaves in this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  assign full  = (count == CntW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    cmd.value = $signed(s_tdata);
    cmd.ins   = s_fire && (s_tuser == REQ_INSERT) && !full;
    cmd.rem   = s_fire && (s_tuser == REQ_REMOVE) && !empty;
    ok        = cmd.ins || cmd.rem;
    if (cmd.ins) begin
      count_next = count + CntW'(1);
    end else if (cmd.rem) begin
      count_next = count - CntW'(1);
    end else begin
      count_next = count;
    end
    count_wide = {{CountOutW{1'b0}}, count_next};
  end

  // Row of cells, largest entry first. Cell i holds an entry while i < count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] prev_v;
    logic signed [ValueW-1:0] next_v;

    assign occ[i] = (count > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_v = VAL_MAX;
    end else begin : g_body
      assign prev_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = cell_val[i];
    end else begin : g_link
      assign next_v = cell_val[i+1];
    end

    bmhq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occ      (occ[i]),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; only loaded when a request is accepted.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tuser        <= ok;
      m_tdata[31:0]  <= cmd.rem ? cell_val[0] : '0;
      m_tdata[36:32] <= count_wide[CountOutW-1:0];
      m_tdata[39:37] <= '0;
    end
  end

endmodule

@@ sv/bmhq_cell.sv @@
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module bmhq_cell
  import bmhq_pkg::*;
(
  input  logic                     clk,
  input  bmhq_cmd_t                cmd,
  input  logic                     occ,
  input  logic signed [ValueW-1:0] prev_val,
  input  logic signed [ValueW-1:0] next_val,
  output logic signed [ValueW-1:0] val
);

  logic own_lt;
  logic prev_lt;

  // An empty cell counts as smaller than any value being inserted.
  always_comb begin
    own_lt  = !occ || (val < cmd.value);
    prev_lt = prev_val < cmd.value;
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (prev_lt) begin
        val <= prev_val;
      end else if (own_lt) begin
        val <= cmd.value;
      end
    end else if (cmd.rem) begin
      val <= next_val;
    end
  end

endmodule

@@ sv/bmhq_checker.sv @@
// Port-level checks for the priority queue core, bound to the top level.
module bmhq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Every accepted request shows its result in the following cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("result missing one cycle after request");

  // A refused request never reports a removed value.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == 32'd0))
    else $error("refused request carries a value");

  // An insert never reports a removed value.
  a_insert_zero: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> (m_tdata[31:0] == 32'd0))
    else $error("insert carries a removed value");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind binary_max_heap_queue_core bmhq_checker u_bmhq_checker (.*);
